// ----- src/lht_pkg.sv -----
// Shared types and constants for the latency histogram tracker.
`timescale 1ns / 1ps

package lht_pkg;

  localparam int NUM_BINS   = 8;
  localparam int BIN_W      = 3;
  localparam int TID_W      = 32;
  localparam int TS_W       = 64;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 136;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // upper bounds (exclusive) of buckets 0..6, in ns
  localparam logic [TS_W-1:0] BUCKET_BOUNDS [NUM_BINS-1] = '{
    64'd1000, 64'd5000, 64'd10000, 64'd50000,
    64'd100000, 64'd500000, 64'd1000000
  };

  typedef struct packed {
    logic load;
    logic mod_step;
    logic rd_en;
    logic calc_en;
    logic sort_en;
    logic commit;
    logic clear_en;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clear_done;
    logic out_free;
  } stat_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_MOD    = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_SORT   = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

endpackage

// ----- src/lht_ctrl.sv -----
// Sequencer for the latency histogram tracker: clear pass and per-beat steps.
`timescale 1ns / 1ps

module lht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lht_pkg::stat_t stat,
  output lht_pkg::cmd_t  cmd
);
  import lht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_FETCH;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.calc_en = 1'b1;
        state_nxt   = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/lht_dp.sv -----
// Datapath: slot tables, slot index, latency and bucket logic, bins, output register.
`timescale 1ns / 1ps

module lht_dp #(
  parameter int SLOTS = 16384
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [lht_pkg::MODE_W-1:0]         in_tuser,
  input  logic [lht_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tuser,
  output logic [lht_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  lht_pkg::cmd_t                      cmd,
  output lht_pkg::stat_t                     stat
);
  import lht_pkg::*;

  localparam int  SLOT_W = $clog2(SLOTS);
  localparam int  ENT_W  = TID_W + TS_W;
  localparam bit  POW2   = (SLOTS & (SLOTS - 1)) == 0;

  // latched item
  logic [MODE_W-1:0] mode_r;
  logic [TID_W-1:0]  id_r;
  logic [TS_W-1:0]   ts_r;
  logic [BIN_W-1:0]  bin_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      id_r   <= in_tdata[31:0];
      ts_r   <= in_tdata[95:32];
      bin_r  <= in_tdata[98:96];
    end
  end

  // slot index = thread_id mod SLOTS
  logic [SLOT_W-1:0] slot;
  logic              mod_done;

  if (POW2) begin : g_pow2
    assign slot     = id_r[SLOT_W-1:0];
    assign mod_done = 1'b1;
  end else begin : g_mod
    localparam int REM_W     = SLOT_W + 1;
    localparam int RECIP_W   = TID_W + 1;
    localparam int RECIP_SH  = TID_W + SLOT_W;
    localparam int PROD_W    = TID_W + RECIP_W;
    localparam int MOD_STEPS = 2;
    localparam int CNT_W     = $clog2(MOD_STEPS + 1);
    // floor(2^RECIP_SH / SLOTS): the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << RECIP_SH) / SLOTS);
    localparam logic [REM_W-1:0]   SLOTS_C = REM_W'(SLOTS);

    logic [PROD_W-1:0] prod_r;
    logic [REM_W-1:0]  q_low;
    logic [REM_W-1:0]  rem_r;
    logic [REM_W-1:0]  rem_fix;
    logic [CNT_W-1:0]  cnt_r;

    // only the low quotient bits matter for the remainder
    assign q_low = prod_r[RECIP_SH +: REM_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.mod_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end

    // step 0: reciprocal multiply; step 1: id - quotient * SLOTS, in [0, 2*SLOTS)
    always_ff @(posedge clk) begin
      if (cmd.mod_step) begin
        if (cnt_r == CNT_W'(0)) begin
          prod_r <= PROD_W'(id_r) * PROD_W'(RECIP);
        end else begin
          rem_r <= id_r[REM_W-1:0] - q_low * SLOTS_C;
        end
      end
    end

    assign rem_fix  = (rem_r >= SLOTS_C) ? rem_r - SLOTS_C : rem_r;
    assign slot     = rem_fix[SLOT_W-1:0];
    assign mod_done = (cnt_r == CNT_W'(MOD_STEPS));
  end

  // clear pass over the valid table after reset
  logic [SLOT_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_en) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // result selection
  logic               match_r;
  logic [TS_W-1:0]    elapsed_r;
  logic [BIN_W-1:0]   bucket_r;
  logic [TS_W-1:0]    hist_r [NUM_BINS];
  logic               do_end;
  logic               do_read;
  logic [BIN_W-1:0]   sel_bin;
  logic [TS_W-1:0]    hist_sel;
  logic [TS_W-1:0]    hist_inc;

  assign do_end   = (mode_r == MODE_END) && match_r;
  assign do_read  = (mode_r == MODE_READ);
  assign sel_bin  = do_read ? bin_r : bucket_r;
  assign hist_sel = hist_r[sel_bin];
  assign hist_inc = hist_sel + 1'b1;

  // valid table: one write port shared by the clear pass and commits
  logic              vld_mem [SLOTS];
  logic              vld_q;
  logic              vld_we;
  logic [SLOT_W-1:0] vld_wa;
  logic              vld_wd;

  always_comb begin
    vld_we = 1'b0;
    vld_wa = slot;
    vld_wd = 1'b0;
    if (cmd.clear_en) begin
      vld_we = 1'b1;
      vld_wa = clr_idx_r;
    end else if (cmd.commit && (mode_r == MODE_START)) begin
      vld_we = 1'b1;
      vld_wd = 1'b1;
    end else if (cmd.commit && do_end) begin
      vld_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[vld_wa] <= vld_wd;
    if (cmd.rd_en) vld_q <= vld_mem[slot];
  end

  // entry table: {tag, start time}
  logic [ENT_W-1:0] ent_mem [SLOTS];
  logic [ENT_W-1:0] ent_q;

  always_ff @(posedge clk) begin
    if (cmd.commit && (mode_r == MODE_START)) ent_mem[slot] <= {id_r, ts_r};
    if (cmd.rd_en) ent_q <= ent_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      match_r   <= vld_q && (ent_q[ENT_W-1:TS_W] == id_r);
      elapsed_r <= ts_r - ent_q[TS_W-1:0];
    end
  end

  logic [BIN_W-1:0] bucket_nxt;

  always_comb begin
    bucket_nxt = BIN_W'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (elapsed_r < BUCKET_BOUNDS[i]) bucket_nxt = BIN_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_en) bucket_r <= bucket_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) hist_r[i] <= '0;
    end else if (cmd.commit && do_end) begin
      hist_r[bucket_r] <= hist_inc;
    end
  end

  // output register
  logic            out_valid_r;
  logic            out_matched_r;
  logic [TS_W-1:0] out_lat_r;
  logic [BIN_W-1:0] out_bucket_r;
  logic [TS_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_matched_r <= do_end;
      out_lat_r     <= do_end ? elapsed_r : '0;
      out_bucket_r  <= (do_end || do_read) ? sel_bin : '0;
      out_count_r   <= do_end ? hist_inc : (do_read ? hist_sel : '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_matched_r;
  assign out_tdata  = {5'b0, out_count_r, out_bucket_r, out_lat_r};

  assign stat.mod_done   = mod_done;
  assign stat.clear_done = (clr_idx_r == SLOT_W'(SLOTS - 1));
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule

// ----- src/latency_histogram_tracker.sv -----
// Top level of the per-thread latency histogram tracker.
//
//  channel | dir | ports                       | contents
//  --------+-----+-----------------------------+--------------------------------------
//  in      | in  | in_tvalid/tready/tuser/tdata | mode; thread_id, timestamp_ns, bin_index
//  out     | out | out_tvalid/tready/tuser/tdata| matched; latency_ns, bucket, bin_count
//
// One beat at a time: accept, slot index, table read, latency, bucket, commit.
// With SLOTS a power of two the slot index is the low thread_id bits; otherwise the slot remainder
// unit adds 2 steps (reciprocal multiply, then remainder) to each beat.
// After reset the valid table is cleared one entry a cycle, with in_tready low
// until the pass ends. A stalled result waits in the output register; the next beat
// is accepted meanwhile and holds only at its commit step.
`timescale 1ns / 1ps

module latency_histogram_tracker #(
  parameter int SLOTS = 16384
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lht_pkg::MODE_W-1:0]     in_tuser,   // [1:0] mode
  input  logic [lht_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] thread_id, [95:32] timestamp_ns,
                                                     // [98:96] bin_index
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tuser,  // [0] matched
  output logic [lht_pkg::OUT_DATA_W-1:0] out_tdata   // [63:0] latency_ns, [66:64] bucket,
                                                     // [130:67] bin_count
);
  import lht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- src/lht_checker.sv -----
// Port-level assertions for the latency histogram tracker, bound to the top level.
`timescale 1ns / 1ps

module lht_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic                           out_tuser,
  input logic [lht_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lht_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one beat in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // no match, no latency
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[63:0] == 64'd0)
    else $error("latency reported without a match");

  // matched end bumps its bin to at least one
  a_matched_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[130:67] != 64'd0)
    else $error("matched result with zero bin count");

  // sub-microsecond latency lands in the first bucket
  a_first_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (out_tdata[63:0] < BUCKET_BOUNDS[0]) |->
      out_tdata[66:64] == 3'd0)
    else $error("short latency sorted into wrong bucket");

endmodule

bind latency_histogram_tracker lht_checker u_lht_checker (.*);
